@@ sv/hrlc_pkg.sv @@
package hrlc_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int unsigned METHOD_COUNT = 3;
    localparam logic [3:0]  VERSION_LEN  = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_MISSING     = 3'd1;
    localparam logic [2:0] ST_NO_CR       = 3'd2;
    localparam logic [2:0] ST_BAD_METHOD  = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;

    localparam logic [1:0] M_GET     = 2'd0;
    localparam logic [1:0] M_POST    = 2'd1;
    localparam logic [1:0] M_CONNECT = 2'd2;

    // Position within the request line. Done means an LF closed the version.
    typedef enum logic [3:0] {
        F_METHOD  = 4'b0001,
        F_URL     = 4'b0010,
        F_VERSION = 4'b0100,
        F_DONE    = 4'b1000
    } t_field;

    typedef struct packed {
        t_field      field;
        logic [3:0]  method_position;
        logic [2:0]  method_candidates;
        logic [15:0] url_count;
        logic [3:0]  version_position;
        logic        version_matches;
        logic        previous_was_cr;
    } t_line_state;

    localparam t_line_state STATE_RESET = '{
        field:             F_METHOD,
        method_position:   4'd0,
        method_candidates: 3'b111,
        url_count:         16'd0,
        version_position:  4'd0,
        version_matches:   1'b1,
        previous_was_cr:   1'b0
    };

    function automatic logic [3:0] method_len(input logic [1:0] code);
        logic [3:0] len;
        case (code)
            M_GET:     len = 4'd3;
            M_POST:    len = 4'd4;
            M_CONNECT: len = 4'd7;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] code,
                                               input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            M_GET: begin
                case (pos)
                    3'd0:    ch = "G";
                    3'd1:    ch = "E";
                    3'd2:    ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            M_POST: begin
                case (pos)
                    3'd0:    ch = "P";
                    3'd1:    ch = "O";
                    3'd2:    ch = "S";
                    3'd3:    ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            M_CONNECT: begin
                case (pos)
                    3'd0:    ch = "C";
                    3'd1:    ch = "O";
                    3'd2:    ch = "N";
                    3'd3:    ch = "N";
                    3'd4:    ch = "E";
                    3'd5:    ch = "C";
                    3'd6:    ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            3'd5:    ch = "1";
            3'd6:    ch = ".";
            default: ch = "1";
        endcase
        return ch;
    endfunction

endpackage

@@ sv/hrlc_step.sv @@
module hrlc_step (
    input  hrlc_pkg::t_line_state i_state,
    input  logic [7:0]            i_line_byte,
    input  logic                  i_end_of_line,
    output hrlc_pkg::t_line_state o_next_state,
    output logic [2:0]            o_status,
    output logic [1:0]            o_method_code,
    output logic [15:0]           o_url_length
);
    import hrlc_pkg::*;

    t_line_state n_state;
    logic        found;
    logic [1:0]  found_code;
    logic [2:0]  status;

    // Fold one byte into the line state.
    always_comb begin
        n_state = i_state;
        unique case (i_state.field)
            F_METHOD: begin
                if (i_line_byte == CH_SPACE) begin
                    n_state.field = F_URL;
                end else begin
                    for (int k = 0; k < METHOD_COUNT; k++) begin
                        if (i_state.method_position >= method_len(2'(k)) ||
                            i_line_byte != method_char(2'(k),
                                                       i_state.method_position[2:0])) begin
                            n_state.method_candidates[k] = 1'b0;
                        end
                    end
                    if (i_state.method_position != 4'hF) begin
                        n_state.method_position = i_state.method_position + 4'd1;
                    end
                end
            end
            F_URL: begin
                if (i_line_byte == CH_SPACE) begin
                    n_state.field = F_VERSION;
                end else if (i_state.url_count != 16'hFFFF) begin
                    n_state.url_count = i_state.url_count + 16'd1;
                end
            end
            F_VERSION: begin
                if (i_line_byte == CH_LF) begin
                    n_state.field = F_DONE;
                end else begin
                    if (i_state.version_position < VERSION_LEN &&
                        i_line_byte != version_char(i_state.version_position[2:0])) begin
                        n_state.version_matches = 1'b0;
                    end
                    n_state.previous_was_cr = (i_line_byte == CH_CR);
                    if (i_state.version_position != 4'hF) begin
                        n_state.version_position = i_state.version_position + 4'd1;
                    end
                end
            end
            F_DONE: begin
                n_state = i_state;
            end
            default: begin
                n_state = i_state;
            end
        endcase
    end

    // The method lengths differ, so at most one candidate can match its length.
    always_comb begin
        found      = 1'b0;
        found_code = M_GET;
        for (int k = METHOD_COUNT - 1; k >= 0; k--) begin
            if (n_state.method_candidates[k] &&
                n_state.method_position == method_len(2'(k))) begin
                found      = 1'b1;
                found_code = 2'(k);
            end
        end
    end

    always_comb begin
        if (n_state.field == F_METHOD || n_state.field == F_URL ||
            n_state.method_position == 4'd0 || n_state.url_count == 16'd0 ||
            n_state.version_position == 4'd0) begin
            status = ST_MISSING;
        end else if (!n_state.previous_was_cr) begin
            status = ST_NO_CR;
        end else if (!found) begin
            status = ST_BAD_METHOD;
        end else if (!(n_state.version_position == VERSION_LEN + 4'd1 &&
                       n_state.version_matches)) begin
            status = ST_BAD_VERSION;
        end else begin
            status = ST_OK;
        end
    end

    assign o_status      = status;
    assign o_method_code = (status == ST_OK) ? found_code : M_GET;
    assign o_url_length  = n_state.url_count;
    assign o_next_state  = i_end_of_line ? STATE_RESET : n_state;

endmodule

@@ sv/http_request_line_checker_core.sv @@
// Latency: a line's result is valid in the cycle after its last byte is accepted.
// Throughput: one byte per clock; a byte is taken even while a result waits,
// as long as the result register is empty or is being drained that cycle.
// Reset (i_rst_n low, synchronous) returns the line state to the start of the
// method field and drops any pending result.
module http_request_line_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_line_byte,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [1:0]  o_method_code,
    output logic [15:0] o_url_length
);
    import hrlc_pkg::*;

    t_line_state r_state;
    t_line_state n_state;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [1:0]  r_method_code;
    logic [15:0] r_url_length;
    logic [2:0]  n_status;
    logic [1:0]  n_method_code;
    logic [15:0] n_url_length;
    logic        in_accept;

    assign o_ready   = !r_out_valid || i_ready;
    assign in_accept = i_valid && o_ready;

    hrlc_step u_step (
        .i_state       (r_state),
        .i_line_byte   (i_line_byte),
        .i_end_of_line (i_end_of_line),
        .o_next_state  (n_state),
        .o_status      (n_status),
        .o_method_code (n_method_code),
        .o_url_length  (n_url_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept && i_end_of_line) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_end_of_line) begin
            r_status      <= n_status;
            r_method_code <= n_method_code;
            r_url_length  <= n_url_length;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_method_code = r_method_code;
    assign o_url_length  = r_url_length;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import hrlc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_BYTES = 260;

    typedef struct {
        logic [2:0]  status;
        logic [1:0]  method_code;
        logic [15:0] url_length;
    } t_verdict;

    // Tracks the line being received and holds the verdicts still owed by the block.
    class line_verdict_board;
        string       method_names[3] = '{"GET", "POST", "CONNECT"};
        logic [1:0]  method_codes[3] = '{M_GET, M_POST, M_CONNECT};
        string       version_text = "HTTP/1.1";
        t_verdict    expected_verdicts[$];
        int          failures;

        t_field      field;
        logic [3:0]  method_pos;
        logic [2:0]  candidates;
        logic [15:0] url_count;
        logic [3:0]  version_pos;
        logic        version_ok;
        logic        last_was_cr;

        function new();
            failures = 0;
            clear_line();
        endfunction

        function void clear_line();
            field       = F_METHOD;
            method_pos  = 4'd0;
            candidates  = 3'b111;
            url_count   = 16'd0;
            version_pos = 4'd0;
            version_ok  = 1'b1;
            last_was_cr = 1'b0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void note_byte(logic [7:0] b, logic eol);
            t_verdict v;
            bit       found;
            case (field)
                F_METHOD: begin
                    if (b == CH_SPACE) begin
                        field = F_URL;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            if (candidates[k] && (method_pos >= method_names[k].len() ||
                                    b != method_names[k][method_pos]))
                                candidates[k] = 1'b0;
                        end
                        if (method_pos != 4'd15)
                            method_pos++;
                    end
                end
                F_URL: begin
                    if (b == CH_SPACE)
                        field = F_VERSION;
                    else if (url_count != 16'hFFFF)
                        url_count++;
                end
                F_VERSION: begin
                    if (b == CH_LF) begin
                        field = F_DONE;
                    end else begin
                        if (version_pos < VERSION_LEN && b != version_text[version_pos])
                            version_ok = 1'b0;
                        last_was_cr = (b == CH_CR);
                        if (version_pos != 4'd15)
                            version_pos++;
                    end
                end
                default: ;
            endcase
            if (!eol)
                return;

            v.method_code = M_GET;
            v.url_length  = url_count;
            found = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (!found && candidates[k] && method_pos == method_names[k].len()) begin
                    found = 1'b1;
                    v.method_code = method_codes[k];
                end
            end
            if (field == F_METHOD || field == F_URL || method_pos == 0 || url_count == 0 ||
                    version_pos == 0)
                v.status = ST_MISSING;
            else if (!last_was_cr)
                v.status = ST_NO_CR;
            else if (!found)
                v.status = ST_BAD_METHOD;
            else if (!(version_pos == VERSION_LEN + 1 && version_ok))
                v.status = ST_BAD_VERSION;
            else
                v.status = ST_OK;
            if (v.status != ST_OK)
                v.method_code = M_GET;
            expected_verdicts.push_back(v);
            clear_line();
        endfunction

        function void check_verdict(logic [2:0] status, logic [1:0] code, logic [15:0] len);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $error("result with no line pending: status %0d, url_length %0d", status, len);
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (code !== want.method_code) begin
                $error("method_code: expected %0d, got %0d", want.method_code, code);
                failures++;
            end
            if (len !== want.url_length) begin
                $error("url_length: expected %0d, got %0d", want.url_length, len);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_line_byte;
    logic        i_end_of_line;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [1:0]  o_method_code;
    logic [15:0] o_url_length;

    line_verdict_board board;
    logic [7:0] line_bytes[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         phase_bytes;
    int         cycle_count;

    string method_pool[11] = '{"GET", "POST", "CONNECT", "GE", "GETT", "POS", "CONNEC",
                               "CONNECTS", "get", "PUT", ""};
    string version_pool[9] = '{"HTTP/1.1\015", "HTTP/1.0\015", "HTTP/1.1", "HTTP/1.1\015\015",
                               "HTTP/1.\015", "HTTP/1.11\015", "\015", "http/1.1\015",
                               "HTTP/1.1 \015"};

    http_request_line_checker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_line_byte   (i_line_byte),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_method_code (o_method_code),
        .o_url_length  (o_url_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Both handshakes are observed here with the values that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_verdict(o_status, o_method_code, o_url_length);
            if (i_valid && o_ready)
                board.note_byte(i_line_byte, i_end_of_line);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] random_url_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_SPACE);
        return b;
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic append_url(input int n);
        repeat (n) line_bytes.push_back(random_url_byte());
    endtask

    // Valid stays high across back-to-back transactions and drops only for an idle gap.
    task automatic send_byte(input logic [7:0] b, input logic eol);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_line_byte   <= b;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        phase_bytes += line_bytes.size();
        line_bytes.delete();
    endtask

    task automatic send_text(input string s);
        append_text(s);
        send_line();
    endtask

    task automatic build_random_line();
        int         kind;
        int         m;
        int         v;
        int         idx;
        logic [7:0] b;
        line_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            // Mostly well-formed lines; the rest use near-miss methods and versions.
            m = (kind < 55) ? $urandom_range(2) : $urandom_range(10);
            v = (kind < 55) ? 0 : $urandom_range(8);
            append_text(method_pool[m]);
            line_bytes.push_back(CH_SPACE);
            append_url($urandom_range(1, 12));
            line_bytes.push_back(CH_SPACE);
            append_text(version_pool[v]);
            if ($urandom_range(4) == 0) begin
                line_bytes.push_back(CH_LF);
                repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(255)));
            end
            if (kind < 55 && $urandom_range(9) < 3) begin
                idx = $urandom_range(line_bytes.size() - 1);
                case ($urandom_range(3))
                    0:       b = CH_SPACE;
                    1:       b = CH_CR;
                    2:       b = CH_LF;
                    default: b = 8'($urandom_range(255));
                endcase
                line_bytes[idx] = b;
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 24)) begin
                if ($urandom_range(3) == 0)
                    line_bytes.push_back(CH_SPACE);
                else
                    line_bytes.push_back(8'($urandom_range(255)));
            end
        end else if (kind < 95) begin
            case ($urandom_range(2))
                0: begin
                    repeat ($urandom_range(16, 20))
                        line_bytes.push_back(8'($urandom_range(65, 90)));
                    append_text(" / HTTP/1.1\015");
                end
                1: begin
                    append_text("GET / HTTP/1.1");
                    repeat ($urandom_range(8, 12)) begin
                        do b = 8'($urandom_range(255)); while (b == CH_LF);
                        line_bytes.push_back(b);
                    end
                    line_bytes.push_back(CH_CR);
                end
                default: begin
                    append_text("POST ");
                    append_url($urandom_range(200, 400));
                    append_text(" HTTP/1.1\015");
                end
            endcase
        end else begin
            case ($urandom_range(3))
                0:       append_text(" / HTTP/1.1\015");
                1:       append_text("GET  HTTP/1.1\015");
                2:       append_text("GET / ");
                default: append_text("GET /");
            endcase
        end
    endtask

    initial begin
        int idle_send[4];
        int idle_recv[4];
        idle_send = '{0, 58, 0, 36};
        idle_recv = '{0, 0, 58, 36};
        board          = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_line_byte    = 8'h00;
        i_end_of_line  = 1'b0;
        i_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("GET / HTTP/1.1\015");
        send_text("POST /a HTTP/1.1\015");
        send_text("CONNECT h:1 HTTP/1.1\015");
        send_text("G");
        send_text("GET / HTTP/1.1");
        send_text("PUT / HTTP/1.1\015");
        send_text("GET / HTTP/1.0\015");
        send_text("GET / HTTP/1.1\015\012x y");
        send_text("GET / ");
        send_text("GE\012T /\012 HTTP/1.1\015");
        send_text("GET / HTTP/1.1 x\015");
        append_text("GET ");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        append_text(" HTTP/1.1\015");
        send_line();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            phase_bytes    = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_random_line();
                send_line();
            end
        end
        i_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
